// ===== design/vrmr_pkg.sv =====
// Shared constants, command codes and helper functions for the vertex mean/spread unit.
package vrmr_pkg;

  localparam int MAX_ENTRIES = 1048576;

  localparam int CNT_W   = 21;
  localparam int COORD_W = 20;
  localparam int SUM_W   = 40;
  localparam int OSQ_W   = 59;
  localparam int SQ_W    = 60;
  localparam int RMS_W   = 21;
  localparam int STEP_W  = 6;

  // Datapath commands
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_UPD   = 4'd1;
  localparam logic [3:0] OP_LOAD  = 4'd2;
  localparam logic [3:0] OP_MDIV  = 4'd3;
  localparam logic [3:0] OP_MUL   = 4'd4;
  localparam logic [3:0] OP_DIFF  = 4'd5;
  localparam logic [3:0] OP_SQRT  = 4'd6;
  localparam logic [3:0] OP_RLOAD = 4'd7;
  localparam logic [3:0] OP_RDIV  = 4'd8;
  localparam logic [3:0] OP_FIN   = 4'd9;
  localparam logic [3:0] OP_PUB   = 4'd10;

  // Action codes
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_MERGE = 2'd1;
  localparam logic [1:0] ACT_SUB   = 2'd2;

  typedef struct packed {
    logic [3:0]        op;
    logic [STEP_W-1:0] step;
  } cmd_t;

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W:0] t);
    logic [SUM_W-1:0] r;
    if (t[SUM_W] != t[SUM_W-1]) begin
      r = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = t[SUM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [SQ_W-1:0] sat_sq_add(input logic [SQ_W-1:0] a,
                                                 input logic [SQ_W-1:0] b);
    logic [SQ_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[SQ_W] ? {SQ_W{1'b1}} : t[SQ_W-1:0];
  endfunction

endpackage

// ===== design/vertex_running_mean_rms_unit.sv =====
// Top level of the vertex running mean and spread unit.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   input   | in        | in_valid/in_stall  | action, x/y/z_coord, other_count/sum/sq
//   output  | out       | out_valid/out_stall| count, mean_x/y/z, rms_x/y/z, overflow
//
// Each accepted item runs an update, then the three axis lanes run in lockstep
// through a 41-step restoring divider for the mean, five partial-product steps,
// a 41-step square root and a second 41-step divide before the result is
// published.
// Reset (rst, synchronous) clears the count, sums and square sums and drops any
// pending result beat.
// in_stall is high from accept until the result is placed in the output register;
// a held result beat waiting on out_stall does not block the next accept.
module vertex_running_mean_rms_unit #(
  parameter int MAX_ENTRIES = vrmr_pkg::MAX_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          action,
  input  logic signed [vrmr_pkg::COORD_W-1:0] x_coord,
  input  logic signed [vrmr_pkg::COORD_W-1:0] y_coord,
  input  logic signed [vrmr_pkg::COORD_W-1:0] z_coord,
  input  logic [vrmr_pkg::CNT_W-1:0]          other_count,
  input  logic signed [vrmr_pkg::SUM_W-1:0]   other_sum_x,
  input  logic signed [vrmr_pkg::SUM_W-1:0]   other_sum_y,
  input  logic signed [vrmr_pkg::SUM_W-1:0]   other_sum_z,
  input  logic [vrmr_pkg::OSQ_W-1:0]          other_sq_x,
  input  logic [vrmr_pkg::OSQ_W-1:0]          other_sq_y,
  input  logic [vrmr_pkg::OSQ_W-1:0]          other_sq_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [vrmr_pkg::CNT_W-1:0]          count,
  output logic signed [vrmr_pkg::COORD_W-1:0] mean_x,
  output logic signed [vrmr_pkg::COORD_W-1:0] mean_y,
  output logic signed [vrmr_pkg::COORD_W-1:0] mean_z,
  output logic [vrmr_pkg::RMS_W-1:0]          rms_x,
  output logic [vrmr_pkg::RMS_W-1:0]          rms_y,
  output logic [vrmr_pkg::RMS_W-1:0]          rms_z,
  output logic                                overflow
);

  vrmr_pkg::cmd_t cmd;

  // sequencer: handshakes and step commands
  vrmr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // state, lanes and result register
  vrmr_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .action      (action),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .z_coord     (z_coord),
    .other_count (other_count),
    .other_sum_x (other_sum_x),
    .other_sum_y (other_sum_y),
    .other_sum_z (other_sum_z),
    .other_sq_x  (other_sq_x),
    .other_sq_y  (other_sq_y),
    .other_sq_z  (other_sq_z),
    .rst         (rst),
    .count       (count),
    .mean_x      (mean_x),
    .mean_y      (mean_y),
    .mean_z      (mean_z),
    .rms_x       (rms_x),
    .rms_y       (rms_y),
    .rms_z       (rms_z),
    .overflow    (overflow)
  );

endmodule

// ===== design/vrmr_lane.sv =====
// One axis: mean division, variance products, square root and final division.
module vrmr_lane (
  input  logic                          clk,
  input  vrmr_pkg::cmd_t                cmd,
  input  logic [vrmr_pkg::CNT_W-1:0]    n,
  input  logic [vrmr_pkg::SUM_W-1:0]    s1,
  input  logic [vrmr_pkg::SQ_W-1:0]     s2,
  output logic [vrmr_pkg::COORD_W-1:0]  mean,
  output logic [vrmr_pkg::RMS_W-1:0]    rms
);

  logic        neg;
  logic [39:0] mag;
  logic [40:0] dq;
  logic [20:0] dr;
  logic [80:0] acc_a;
  logic [79:0] acc_b;
  logic [81:0] rad;
  logic [40:0] root;
  logic [43:0] srem;

  logic [21:0] r_sh;
  logic [21:0] r_diff;
  logic        q_bit;
  logic [20:0] a_op;
  logic [29:0] b_op;
  logic [50:0] prod;
  logic [80:0] term;
  logic [43:0] rem2;
  logic [43:0] trial;
  logic [39:0] s1_abs;

  assign s1_abs = s1[39] ? (40'd0 - s1) : s1;

  // divider step: one quotient bit per cycle
  assign r_sh   = {dr, dq[40]};
  assign r_diff = r_sh - {1'b0, n};
  assign q_bit  = (r_sh >= {1'b0, n});

  always_comb begin
    a_op = '0;
    b_op = '0;
    term = '0;
    unique case (cmd.step[2:0])
      3'd0: begin a_op = n;              b_op = s2[29:0]; end
      3'd1: begin a_op = n;              b_op = s2[59:30]; end
      3'd2: begin a_op = {1'b0, mag[19:0]};  b_op = {10'd0, mag[19:0]}; end
      3'd3: begin a_op = {1'b0, mag[19:0]};  b_op = {10'd0, mag[39:20]}; end
      3'd4: begin a_op = {1'b0, mag[39:20]}; b_op = {10'd0, mag[39:20]}; end
      default: begin a_op = '0; b_op = '0; end
    endcase
    prod = 51'(a_op) * 51'(b_op);
    unique case (cmd.step[2:0])
      3'd1:    term = 81'(prod) << 30;
      3'd3:    term = 81'(prod) << 21;
      3'd4:    term = 81'(prod) << 40;
      default: term = 81'(prod);
    endcase
  end

  assign rem2  = {srem[41:0], rad[81:80]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      vrmr_pkg::OP_LOAD: begin
        neg   <= s1[39];
        mag   <= s1_abs;
        dq    <= {1'b0, s1_abs};
        dr    <= '0;
        acc_a <= '0;
        acc_b <= '0;
      end
      vrmr_pkg::OP_MDIV, vrmr_pkg::OP_RDIV: begin
        dr <= q_bit ? r_diff[20:0] : r_sh[20:0];
        dq <= {dq[39:0], q_bit};
      end
      vrmr_pkg::OP_MUL: begin
        if (cmd.step[2:0] == 3'd0) begin
          // quotient is complete: fold in sign and clamp
          if (neg) begin
            mean <= (dq > 41'd524288) ? 20'h80000 : (20'd0 - dq[19:0]);
          end else begin
            mean <= (dq > 41'd524287) ? 20'h7FFFF : dq[19:0];
          end
        end
        if (cmd.step[2:0] <= 3'd1) begin
          acc_a <= acc_a + term;
        end else begin
          acc_b <= acc_b + term[79:0];
        end
      end
      vrmr_pkg::OP_DIFF: begin
        rad  <= (acc_a > {1'b0, acc_b}) ? {1'b0, acc_a - {1'b0, acc_b}} : '0;
        root <= '0;
        srem <= '0;
      end
      vrmr_pkg::OP_SQRT: begin
        rad <= {rad[79:0], 2'b00};
        if (rem2 >= trial) begin
          srem <= rem2 - trial;
          root <= {root[39:0], 1'b1};
        end else begin
          srem <= rem2;
          root <= {root[39:0], 1'b0};
        end
      end
      vrmr_pkg::OP_RLOAD: begin
        dq <= root;
        dr <= '0;
      end
      vrmr_pkg::OP_FIN: begin
        rms <= (dq > 41'd2097151) ? {vrmr_pkg::RMS_W{1'b1}} : dq[20:0];
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/vrmr_dp.sv =====
// Datapath: accumulated state, three axis lanes and the result register.
module vrmr_dp #(
  parameter int MAX_ENTRIES = vrmr_pkg::MAX_ENTRIES
) (
  input  logic                                clk,
  input  vrmr_pkg::cmd_t                      cmd,
  input  logic [1:0]                          action,
  input  logic signed [vrmr_pkg::COORD_W-1:0] x_coord,
  input  logic signed [vrmr_pkg::COORD_W-1:0] y_coord,
  input  logic signed [vrmr_pkg::COORD_W-1:0] z_coord,
  input  logic [vrmr_pkg::CNT_W-1:0]          other_count,
  input  logic signed [vrmr_pkg::SUM_W-1:0]   other_sum_x,
  input  logic signed [vrmr_pkg::SUM_W-1:0]   other_sum_y,
  input  logic signed [vrmr_pkg::SUM_W-1:0]   other_sum_z,
  input  logic [vrmr_pkg::OSQ_W-1:0]          other_sq_x,
  input  logic [vrmr_pkg::OSQ_W-1:0]          other_sq_y,
  input  logic [vrmr_pkg::OSQ_W-1:0]          other_sq_z,
  input  logic                                rst,
  output logic [vrmr_pkg::CNT_W-1:0]          count,
  output logic signed [vrmr_pkg::COORD_W-1:0] mean_x,
  output logic signed [vrmr_pkg::COORD_W-1:0] mean_y,
  output logic signed [vrmr_pkg::COORD_W-1:0] mean_z,
  output logic [vrmr_pkg::RMS_W-1:0]          rms_x,
  output logic [vrmr_pkg::RMS_W-1:0]          rms_y,
  output logic [vrmr_pkg::RMS_W-1:0]          rms_z,
  output logic                                overflow
);

  logic [vrmr_pkg::CNT_W-1:0]   n;
  logic [vrmr_pkg::SUM_W-1:0]   sums [3];
  logic [vrmr_pkg::SQ_W-1:0]    sqs  [3];
  logic                         ovf;

  logic [vrmr_pkg::COORD_W-1:0] crd  [3];
  logic [vrmr_pkg::SUM_W-1:0]   osum [3];
  logic [vrmr_pkg::OSQ_W-1:0]   osq  [3];
  logic [vrmr_pkg::COORD_W-1:0] lmean [3];
  logic [vrmr_pkg::RMS_W-1:0]   lrms  [3];

  logic [vrmr_pkg::CNT_W:0] n_inc;
  logic [vrmr_pkg::CNT_W:0] n_merge;

  assign crd  = '{x_coord, y_coord, z_coord};
  assign osum = '{other_sum_x, other_sum_y, other_sum_z};
  assign osq  = '{other_sq_x, other_sq_y, other_sq_z};

  assign n_inc   = {1'b0, n} + 22'd1;
  assign n_merge = {1'b0, n} + {1'b0, other_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      n    <= '0;
      ovf  <= 1'b0;
      sums <= '{default: '0};
      sqs  <= '{default: '0};
    end else if (cmd.op == vrmr_pkg::OP_UPD) begin
      ovf <= 1'b0;
      unique case (action)
        vrmr_pkg::ACT_ADD: begin
          if (n_inc > 22'(MAX_ENTRIES)) begin
            ovf <= 1'b1;
          end else begin
            n <= n_inc[vrmr_pkg::CNT_W-1:0];
            for (int i = 0; i < 3; i++) begin
              sums[i] <= vrmr_pkg::sat_sum({sums[i][39], sums[i]}
                                           + {{21{crd[i][19]}}, crd[i]});
              sqs[i]  <= vrmr_pkg::sat_sq_add(sqs[i], 60'($signed(crd[i])
                                                          * $signed(crd[i])));
            end
          end
        end
        vrmr_pkg::ACT_MERGE: begin
          if (n_merge > 22'(MAX_ENTRIES)) begin
            ovf <= 1'b1;
          end else begin
            n <= n_merge[vrmr_pkg::CNT_W-1:0];
            for (int i = 0; i < 3; i++) begin
              sums[i] <= vrmr_pkg::sat_sum({sums[i][39], sums[i]}
                                           + {osum[i][39], osum[i]});
              sqs[i]  <= vrmr_pkg::sat_sq_add(sqs[i], {1'b0, osq[i]});
            end
          end
        end
        vrmr_pkg::ACT_SUB: begin
          if (other_count >= n) begin
            n    <= '0;
            sums <= '{default: '0};
            sqs  <= '{default: '0};
          end else begin
            n <= n - other_count;
            for (int i = 0; i < 3; i++) begin
              sums[i] <= vrmr_pkg::sat_sum({sums[i][39], sums[i]}
                                           - {osum[i][39], osum[i]});
              sqs[i]  <= ({1'b0, osq[i]} >= sqs[i]) ? '0 : (sqs[i] - {1'b0, osq[i]});
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    vrmr_lane u_lane (
      .clk  (clk),
      .cmd  (cmd),
      .n    (n),
      .s1   (sums[g]),
      .s2   (sqs[g]),
      .mean (lmean[g]),
      .rms  (lrms[g])
    );
  end

  // result register; empty state reports zero means and rms values
  always_ff @(posedge clk) begin
    if (cmd.op == vrmr_pkg::OP_PUB) begin
      count    <= n;
      overflow <= ovf;
      mean_x   <= (n == '0) ? '0 : lmean[0];
      mean_y   <= (n == '0) ? '0 : lmean[1];
      mean_z   <= (n == '0) ? '0 : lmean[2];
      rms_x    <= (n == '0) ? '0 : lrms[0];
      rms_y    <= (n == '0) ? '0 : lrms[1];
      rms_z    <= (n == '0) ? '0 : lrms[2];
    end
  end

endmodule

// ===== design/vrmr_ctrl.sv =====
// Controller: sequences update, divisions, products and square root; owns the handshakes.
module vrmr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output vrmr_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_MDIV  = 4'd2;
  localparam logic [3:0] ST_MUL   = 4'd3;
  localparam logic [3:0] ST_DIFF  = 4'd4;
  localparam logic [3:0] ST_SQRT  = 4'd5;
  localparam logic [3:0] ST_RLOAD = 4'd6;
  localparam logic [3:0] ST_RDIV  = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  localparam logic [vrmr_pkg::STEP_W-1:0] DIV_LAST = 6'd40;
  localparam logic [vrmr_pkg::STEP_W-1:0] MUL_LAST = 6'd4;

  logic [3:0]                  state;
  logic [3:0]                  state_next;
  logic [vrmr_pkg::STEP_W-1:0] step;
  logic [vrmr_pkg::STEP_W-1:0] step_next;
  logic                        can_pub;

  assign in_stall = (state != ST_IDLE);
  assign can_pub  = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd.op     = vrmr_pkg::OP_NONE;
    cmd.step   = step;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = vrmr_pkg::OP_UPD;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.op     = vrmr_pkg::OP_LOAD;
        step_next  = '0;
        state_next = ST_MDIV;
      end
      ST_MDIV: begin
        cmd.op    = vrmr_pkg::OP_MDIV;
        step_next = step + 6'd1;
        if (step == DIV_LAST) begin
          step_next  = '0;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.op    = vrmr_pkg::OP_MUL;
        step_next = step + 6'd1;
        if (step == MUL_LAST) begin
          step_next  = '0;
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.op     = vrmr_pkg::OP_DIFF;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op    = vrmr_pkg::OP_SQRT;
        step_next = step + 6'd1;
        if (step == DIV_LAST) begin
          step_next  = '0;
          state_next = ST_RLOAD;
        end
      end
      ST_RLOAD: begin
        cmd.op     = vrmr_pkg::OP_RLOAD;
        state_next = ST_RDIV;
      end
      ST_RDIV: begin
        cmd.op    = vrmr_pkg::OP_RDIV;
        step_next = step + 6'd1;
        if (step == DIV_LAST) begin
          step_next  = '0;
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.op     = vrmr_pkg::OP_FIN;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (can_pub) begin
          cmd.op     = vrmr_pkg::OP_PUB;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd.op == vrmr_pkg::OP_PUB) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_pub_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == vrmr_pkg::OP_PUB) |=> out_valid) else $error("result beat lost");
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_LOAD)) else $error("accept not sequenced");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> (cmd.op != vrmr_pkg::OP_PUB))
    else $error("waiting result overwritten");
`endif

endmodule
